>>> sv/assert_macros.svh
// Assertion helpers, sampled on clk_i and disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SSL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define SSL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/ssl_pkg.sv
package ssl_pkg;

  localparam int WORD_BITS = 16;
  localparam int CNT_W     = $clog2(WORD_BITS);

  // Input tdata layout.
  localparam int IN_TDATA_W = 24;
  localparam int DEST_LSB   = 0;
  localparam int DWORD_LSB  = 2;
  localparam int DWORD_W    = 16;
  localparam int LDB_BIT    = 18;

  localparam int OUT_TDATA_W = 8;
  localparam int EN_W        = 3;

  typedef enum logic [1:0] {
    DEST_LEFT  = 2'd0,
    DEST_RIGHT = 2'd1,
    DEST_TUNER = 2'd2,
    DEST_NONE  = 2'd3
  } dest_e;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_LOAD  = 2'd2,
    KIND_PULSE = 2'd3
  } frame_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DATA,
    ST_LOAD,
    ST_PULSE
  } state_e;

  typedef struct packed {
    logic        load;
    logic        shift;
    frame_kind_e kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic display;
  } dp_status_t;

endpackage

>>> sv/ssl_ctrl.sv
module ssl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_last_o,
  input  ssl_pkg::dp_status_t status_i,
  output ssl_pkg::ctrl_cmd_t  cmd_o
);
  import ssl_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b1;
    out_last_o  = 1'b0;
    cmd_o.load  = 1'b0;
    cmd_o.shift = 1'b0;
    cmd_o.kind  = KIND_START;
    case (state_q)
      ST_IDLE: begin
        out_valid_o = 1'b0;
        in_ready_o  = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_START;
        end
      end
      ST_START: begin
        if (out_ready_i) begin
          state_d = ST_DATA;
        end
      end
      ST_DATA: begin
        cmd_o.kind = KIND_DATA;
        if (out_ready_i) begin
          cmd_o.shift = 1'b1;
          if (status_i.cnt_last) begin
            state_d = status_i.display ? ST_LOAD : ST_PULSE;
          end
        end
      end
      ST_LOAD: begin
        cmd_o.kind = KIND_LOAD;
        if (out_ready_i) begin
          state_d = ST_PULSE;
        end
      end
      ST_PULSE: begin
        cmd_o.kind = KIND_PULSE;
        out_last_o = 1'b1;
        // Take the next word in the same cycle the load pulse transfers.
        if (out_ready_i) begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            cmd_o.load = 1'b1;
            state_d    = ST_START;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        out_valid_o = 1'b0;
        state_d     = ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/ssl_dp.sv
module ssl_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [ssl_pkg::IN_TDATA_W-1:0]    in_data_i,
  input  ssl_pkg::ctrl_cmd_t                cmd_i,
  output ssl_pkg::dp_status_t               status_o,
  output logic [ssl_pkg::OUT_TDATA_W-1:0]   out_data_o,
  output logic [1:0]                        out_kind_o
);
  import ssl_pkg::*;

  logic [1:0]           dest_q;
  logic [WORD_BITS-1:0] shift_q;
  logic                 ldb_q;
  logic [CNT_W-1:0]     cnt_q;

  logic            tuner;
  logic            serial_bit;
  logic [EN_W-1:0] enables;

  assign tuner = (dest_q == DEST_TUNER);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.shift) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dest_q  <= in_data_i[DEST_LSB +: 2];
      shift_q <= WORD_BITS'(in_data_i[DWORD_LSB +: DWORD_W]);
      ldb_q   <= in_data_i[LDB_BIT];
    end else if (cmd_i.shift) begin
      // Tuner takes MSB first, displays LSB first.
      if (tuner) begin
        shift_q <= {shift_q[WORD_BITS-2:0], 1'b0};
      end else begin
        shift_q <= {1'b0, shift_q[WORD_BITS-1:1]};
      end
    end
  end

  assign status_o.cnt_last = (cnt_q == CNT_W'(WORD_BITS - 1));
  assign status_o.display  = (dest_q == DEST_LEFT) || (dest_q == DEST_RIGHT);

  always_comb begin
    serial_bit = 1'b0;
    enables    = '0;
    case (dest_q)
      DEST_LEFT:  enables = 3'b001;
      DEST_RIGHT: enables = 3'b010;
      DEST_TUNER: enables = 3'b100;
      default:    enables = '0;
    endcase
    case (cmd_i.kind)
      KIND_START: serial_bit = 1'b0;
      KIND_DATA:  serial_bit = tuner ? shift_q[WORD_BITS-1] : shift_q[0];
      KIND_LOAD:  serial_bit = ldb_q;
      KIND_PULSE: begin
        serial_bit = 1'b0;
        enables    = '0;
      end
      default:    serial_bit = 1'b0;
    endcase
  end

  assign out_data_o = {{(OUT_TDATA_W - EN_W - 1){1'b0}}, enables, serial_bit};
  assign out_kind_o = cmd_i.kind;

endmodule

>>> sv/strobed_serial_word_loader_core.sv
// Channel   Dir  Payload
// s_axis    in   tdata: destination, data_word, load_bit
// m_axis    out  tdata: serial_data, enable_lines; tuser: frame_kind; tlast: last_frame
//
// One frame per cycle while m_axis_tready is high: a display word is sent as start,
// 16 data bits, load bit and load pulse frames; a tuner word has no load bit frame.
// The frame sequencer in ssl_ctrl sets this; a new word is taken in the cycle the
// load pulse transfers, so back-to-back words run without a gap.
// Reset clears the sequencer to idle; a low m_axis_tready holds the current frame.
module strobed_serial_word_loader_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [1:0] destination, [17:2] data_word, [18] load_bit, [23:19] zero
  input  logic [ssl_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] serial_data, [3:1] enable_lines, [7:4] zero
  output logic [ssl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // [1:0] frame_kind
  output logic [1:0]                        m_axis_tuser,
  output logic                              m_axis_tlast
);
  import ssl_pkg::*;

  `include "assert_macros.svh"

  ctrl_cmd_t  cmd;
  dp_status_t status;

  ssl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_last_o  (m_axis_tlast),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ssl_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (m_axis_tdata),
    .out_kind_o (m_axis_tuser)
  );

  `SSL_ASSERT_NEXT(a_accept_starts, s_axis_tvalid && s_axis_tready,
                   m_axis_tvalid && (m_axis_tuser == KIND_START))
  `SSL_ASSERT_IMPL(a_last_is_pulse, m_axis_tvalid && m_axis_tlast,
                   (m_axis_tuser == KIND_PULSE) && (m_axis_tdata[3:0] == 4'd0))
  `SSL_ASSERT_IMPL(a_load_display, m_axis_tvalid && (m_axis_tuser == KIND_LOAD),
                   !m_axis_tdata[3] && (m_axis_tdata[2:1] != 2'd0))
  `SSL_ASSERT_IMPL(a_shift_in_data, cmd.shift,
                   m_axis_tvalid && m_axis_tready && (m_axis_tuser == KIND_DATA))

endmodule
